[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the hex loader
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

[hw/rtl/ihex_pkg.sv]
// Types, codes and helpers of the Intel HEX record loader
package ihex_pkg;

    localparam int IMAGE_ADDR_BITS_DEF = 16;
    localparam int MAX_LINE_CHARS_DEF  = 256;
    localparam int RB_DEPTH            = 255;
    localparam int RB_AW               = 8;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_NONE    = 3'd0,
        STAT_STORED  = 3'd1,
        STAT_OTHER   = 3'd2,
        STAT_SHORT   = 3'd3,
        STAT_CSUM    = 3'd4,
        STAT_RANGE   = 3'd5,
        STAT_SKIPPED = 3'd6
    } status_t;

    localparam logic [7:0] REC_DATA   = 8'h00;
    localparam logic [7:0] REC_EXTLIN = 8'h04;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EOL    = 5'b00010,
        ST_COMMIT = 5'b00100,
        ST_READ   = 5'b01000,
        ST_CLEAR  = 5'b10000
    } state_t;

    // Map an ASCII hex digit to its value; anything else reads as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        priority if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else begin
            d = 8'h00;
        end
        return d[3:0];
    endfunction

endpackage

[hw/rtl/intel_hex_record_loader_top.sv]
// Intel HEX record loader: line parser, record store and byte image
// Takes Intel HEX text one character per word and loads a byte image of
// 2**IMAGE_ADDR_BITS bytes held in RAM. A newline moves to a line-end state
// that checks the line, then a valid data record is copied from the record
// store into the image at one byte a cycle through the single image write
// port. A read passes through a read state (registered RAM read). After
// reset and after a clear command the image is swept to 0xFF one byte a
// cycle; no word is taken then. Every accepted word returns exactly one
// result word.
`include "assert_macros.svh"
module intel_hex_record_loader_top #(
    parameter int IMAGE_ADDR_BITS = ihex_pkg::IMAGE_ADDR_BITS_DEF,
    parameter int MAX_LINE_CHARS  = ihex_pkg::MAX_LINE_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_char_in,
    input  logic [15:0] s_read_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_line_status,
    output logic [7:0]  m_read_data,
    output logic [16:0] m_used_size,
    output logic [15:0] m_upper_address
);

    localparam int AB = IMAGE_ADDR_BITS;
    localparam int LW = $clog2(MAX_LINE_CHARS);
    localparam int SW = IMAGE_ADDR_BITS + 1;
    localparam logic [LW-1:0] LINE_LIM = LW'(MAX_LINE_CHARS - 1);
    localparam logic [32:0]   IMG_SIZE = 33'(1) << IMAGE_ADDR_BITS;

    ihex_pkg::state_t state_reg, state_next;
    logic [LW-1:0] line_len_reg, line_len_next;
    logic          ok_start_reg, ok_start_next;
    logic [3:0]    pair_reg, pair_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    count_reg, count_next;
    logic [15:0]   rec_addr_reg, rec_addr_next;
    logic [7:0]    type_reg, type_next;
    logic [15:0]   ext_reg, ext_next;
    logic [15:0]   upper_reg, upper_next;
    logic [SW-1:0] size_reg, size_next;
    logic [7:0]    idx_reg, idx_next;
    logic [AB-1:0] base_reg, base_next;
    logic          pend_reg, pend_next;
    logic [AB-1:0] waddr_reg, waddr_next;
    logic [AB-1:0] clr_reg, clr_next;
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic [16:0]   m_size_reg, m_size_next;
    logic [15:0]   m_upper_reg, m_upper_next;

    logic          acc;
    logic          dig_en;
    logic [3:0]    dig_v;
    logic [LW-1:0] bidx;
    logic [LW-1:0] bm4;
    logic [7:0]    byte_val;
    logic [7:0]    cnt_eff;
    logic          rb_we;
    logic [7:0]    rb_wdata;
    logic [7:0]    rb_rdata;
    logic          img_we;
    logic [AB-1:0] img_waddr;
    logic [7:0]    img_wdata;
    logic [AB-1:0] img_raddr;
    logic [7:0]    img_rdata;
    logic [23:0]   raddr_wide;
    logic [11:0]   len12;
    logic [11:0]   short_thr;
    logic [31:0]   base32;
    logic [32:0]   end33;
    logic [24:0]   size_wide;
    logic          issue;

    assign acc     = s_valid && s_ready;
    assign s_ready = (state_reg == ihex_pkg::ST_IDLE) && !pend_reg
                     && (!m_valid_reg || m_ready);

    // pick the digit that this word feeds into the byte decoder
    always_comb begin
        dig_en = 1'b0;
        dig_v  = 4'h0;
        if (acc && ihex_pkg::cmd_t'(s_command) == ihex_pkg::CMD_CHAR) begin
            if (s_char_in == ihex_pkg::CHAR_LF) begin
                dig_en = (line_len_reg >= LW'(2)) && !line_len_reg[0];
            end else if (line_len_reg < LINE_LIM && line_len_reg != '0) begin
                dig_en = 1'b1;
                dig_v  = ihex_pkg::nibble_of(s_char_in);
            end
        end
    end

    assign bidx     = (line_len_reg - LW'(2)) >> 1;
    assign bm4      = bidx - LW'(4);
    assign byte_val = {pair_reg, dig_v};
    assign cnt_eff  = (bidx == '0) ? byte_val : count_reg;

    // store data bytes of the record as they complete
    assign rb_we    = dig_en && !line_len_reg[0] && (bidx >= LW'(4))
                      && (11'(bm4) < 11'(count_reg));
    assign rb_wdata = byte_val;

    // line end checks on the settled field registers
    assign len12     = 12'(line_len_reg) + 12'd1;
    assign short_thr = 12'd11 + {3'b000, count_reg, 1'b0};
    assign base32    = {upper_reg, rec_addr_reg};
    assign end33     = 33'(base32) + 33'(count_reg);
    assign issue     = idx_reg != count_reg;

    always_comb begin
        state_next    = state_reg;
        line_len_next = line_len_reg;
        ok_start_next = ok_start_reg;
        pair_next     = pair_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        rec_addr_next = rec_addr_reg;
        type_next     = type_reg;
        ext_next      = ext_reg;
        upper_next    = upper_reg;
        size_next     = size_reg;
        idx_next      = idx_reg;
        base_next     = base_reg;
        pend_next     = 1'b0;
        waddr_next    = waddr_reg;
        clr_next      = clr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_size_next   = m_size_reg;
        m_upper_next  = m_upper_reg;

        // decode one digit into the record fields
        if (dig_en) begin
            if (line_len_reg[0]) begin
                pair_next = dig_v;
            end else begin
                if (bidx == LW'(0)) count_next = byte_val;
                if (bidx == LW'(1)) rec_addr_next = {byte_val, rec_addr_reg[7:0]};
                if (bidx == LW'(2)) rec_addr_next = {rec_addr_reg[15:8], byte_val};
                if (bidx == LW'(3)) type_next = byte_val;
                if (bidx == LW'(4)) ext_next = {byte_val, ext_reg[7:0]};
                if (bidx == LW'(5)) ext_next = {ext_reg[15:8], byte_val};
                if (11'(bidx) <= 11'(cnt_eff) + 11'd4) sum_next = sum_reg + byte_val;
            end
        end

        unique case (state_reg)
            ihex_pkg::ST_IDLE: begin
                if (acc) begin
                    unique case (ihex_pkg::cmd_t'(s_command))
                        ihex_pkg::CMD_CHAR: begin
                            if (s_char_in == ihex_pkg::CHAR_LF) begin
                                state_next = ihex_pkg::ST_EOL;
                            end else begin
                                if (line_len_reg < LINE_LIM) begin
                                    if (line_len_reg == '0) begin
                                        ok_start_next = s_char_in == ihex_pkg::CHAR_COLON;
                                    end
                                    line_len_next = line_len_reg + LW'(1);
                                end
                                m_valid_next  = 1'b1;
                                m_status_next = ihex_pkg::STAT_NONE;
                                m_data_next   = 8'h00;
                                m_size_next   = size_wide[16:0];
                                m_upper_next  = upper_reg;
                            end
                        end
                        ihex_pkg::CMD_READ: begin
                            state_next = ihex_pkg::ST_READ;
                        end
                        ihex_pkg::CMD_CLEAR: begin
                            line_len_next = '0;
                            ok_start_next = 1'b0;
                            pair_next     = 4'h0;
                            sum_next      = 8'h00;
                            count_next    = 8'h00;
                            rec_addr_next = 16'h0000;
                            type_next     = 8'h00;
                            ext_next      = 16'h0000;
                            upper_next    = 16'h0000;
                            size_next     = '0;
                            clr_next      = '0;
                            state_next    = ihex_pkg::ST_CLEAR;
                            m_valid_next  = 1'b1;
                            m_status_next = ihex_pkg::STAT_NONE;
                            m_data_next   = 8'h00;
                            m_size_next   = 17'd0;
                            m_upper_next  = 16'h0000;
                        end
                        ihex_pkg::CMD_NONE: begin
                            m_valid_next  = 1'b1;
                            m_status_next = ihex_pkg::STAT_NONE;
                            m_data_next   = 8'h00;
                            m_size_next   = size_wide[16:0];
                            m_upper_next  = upper_reg;
                        end
                        default: begin
                            state_next = ihex_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ihex_pkg::ST_EOL: begin
                state_next   = ihex_pkg::ST_IDLE;
                m_valid_next = 1'b1;
                m_data_next  = 8'h00;
                priority if (len12 <= 12'd9 || !ok_start_reg) begin
                    m_status_next = ihex_pkg::STAT_SKIPPED;
                end else if (len12 < short_thr) begin
                    m_status_next = ihex_pkg::STAT_SHORT;
                end else if (sum_reg != 8'h00) begin
                    m_status_next = ihex_pkg::STAT_CSUM;
                end else if (type_reg == ihex_pkg::REC_DATA) begin
                    if (end33 > IMG_SIZE) begin
                        m_status_next = ihex_pkg::STAT_RANGE;
                    end else begin
                        m_status_next = ihex_pkg::STAT_STORED;
                        if (end33 > 33'(size_reg)) size_next = SW'(end33);
                        base_next = base32[AB-1:0];
                        idx_next  = 8'h00;
                        if (count_reg != 8'h00) state_next = ihex_pkg::ST_COMMIT;
                    end
                end else begin
                    if (type_reg == ihex_pkg::REC_EXTLIN && len12 > 12'd14) begin
                        upper_next = ext_reg;
                    end
                    m_status_next = ihex_pkg::STAT_OTHER;
                end
                m_size_next   = 17'(25'(size_next));
                m_upper_next  = upper_next;
                // start the next line afresh; hold the count for the copy
                line_len_next = '0;
                ok_start_next = 1'b0;
                sum_next      = 8'h00;
                pair_next     = 4'h0;
                if (state_next != ihex_pkg::ST_COMMIT) count_next = 8'h00;
            end
            ihex_pkg::ST_COMMIT: begin
                // issue one store read, write the byte read last cycle
                if (issue) begin
                    idx_next   = idx_reg + 8'd1;
                    pend_next  = 1'b1;
                    waddr_next = base_reg + AB'(idx_reg);
                end else begin
                    count_next = 8'h00;
                    state_next = ihex_pkg::ST_IDLE;
                end
            end
            ihex_pkg::ST_READ: begin
                state_next    = ihex_pkg::ST_IDLE;
                m_valid_next  = 1'b1;
                m_status_next = ihex_pkg::STAT_NONE;
                m_data_next   = img_rdata;
                m_size_next   = size_wide[16:0];
                m_upper_next  = upper_reg;
            end
            ihex_pkg::ST_CLEAR: begin
                clr_next = clr_reg + AB'(1);
                if (&clr_reg) state_next = ihex_pkg::ST_IDLE;
            end
            default: begin
                state_next = ihex_pkg::ST_IDLE;
            end
        endcase
    end

    assign size_wide = 25'(size_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ihex_pkg::ST_CLEAR;
            line_len_reg <= '0;
            ok_start_reg <= 1'b0;
            pair_reg     <= 4'h0;
            sum_reg      <= 8'h00;
            count_reg    <= 8'h00;
            rec_addr_reg <= 16'h0000;
            type_reg     <= 8'h00;
            ext_reg      <= 16'h0000;
            upper_reg    <= 16'h0000;
            size_reg     <= '0;
            idx_reg      <= 8'h00;
            pend_reg     <= 1'b0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            line_len_reg <= line_len_next;
            ok_start_reg <= ok_start_next;
            pair_reg     <= pair_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            rec_addr_reg <= rec_addr_next;
            type_reg     <= type_next;
            ext_reg      <= ext_next;
            upper_reg    <= upper_next;
            size_reg     <= size_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        waddr_reg    <= waddr_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_size_reg   <= m_size_next;
        m_upper_reg  <= m_upper_next;
    end

    // image port: sweep fill or commit write, reads straight from the port
    assign img_we     = pend_reg || (state_reg == ihex_pkg::ST_CLEAR);
    assign img_waddr  = pend_reg ? waddr_reg : clr_reg;
    assign img_wdata  = pend_reg ? rb_rdata : ihex_pkg::FILL_BYTE;
    assign raddr_wide = 24'(s_read_address);
    assign img_raddr  = raddr_wide[AB-1:0];

    ihex_ram #(
        .WIDTH (8),
        .DEPTH (1 << IMAGE_ADDR_BITS)
    ) u_image (
        .clk   (aclk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    ihex_ram #(
        .WIDTH (8),
        .DEPTH (ihex_pkg::RB_DEPTH)
    ) u_record (
        .clk   (aclk),
        .we    (rb_we),
        .waddr (ihex_pkg::RB_AW'(bm4)),
        .wdata (rb_wdata),
        .raddr (idx_reg),
        .rdata (rb_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_line_status   = m_status_reg;
    assign m_read_data     = m_data_reg;
    assign m_used_size     = m_size_reg;
    assign m_upper_address = m_upper_reg;

    `ASSERT_NEVER(a_no_commit_in_sweep, aclk, aresetn, (state_reg == ihex_pkg::ST_CLEAR) && pend_reg, "commit write during fill sweep")
    `ASSERT_CLK(a_write_trails_read, aclk, aresetn, pend_reg |-> (idx_reg != 8'h00), "commit write without a store read")
    `ASSERT_CLK(a_read_result, aclk, aresetn, (acc && s_command == ihex_pkg::CMD_READ) |=> (state_reg == ihex_pkg::ST_READ && !m_valid_reg), "read did not reach read state with free output")
    `ASSERT_CLK(a_eol_result, aclk, aresetn, (state_reg == ihex_pkg::ST_EOL) |=> m_valid_reg, "line end gave no result")

endmodule

[hw/rtl/ihex_ram.sv]
// Generic single-clock RAM: one write port, one registered read port
module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
